@@ sv/mdrb_pkg.sv @@
`default_nettype none

package mdrb_pkg;

   localparam int DEPTH     = 16;
   localparam int ITEM_BITS = 32;

   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int QLEN_BITS = 5;
   localparam int DATA_BITS = 32;
   localparam int WAIT_BITS = 5;
   localparam int FUNC_BITS = 2;
   localparam int STAT_BITS = 2;

   localparam logic [QLEN_BITS-1:0] QLEN_RESET = 5'd16;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_SEND_BACK  = 2'd0,
      FUNC_SEND_FRONT = 2'd1,
      FUNC_RECEIVE    = 2'd2,
      FUNC_PEEK       = 2'd3
   } func_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_PASS  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      status_type            status;
      logic [DATA_BITS-1:0]  read_data;
      logic [WAIT_BITS-1:0]  items_waiting;
   } rsp_type;

   function automatic logic [CNT_BITS-1:0] eff_len(input logic [QLEN_BITS-1:0] q);
      int unsigned l;
      l = 32'(q);
      if (l == 0) begin
         l = 1;
      end
      if (l > DEPTH) begin
         l = DEPTH;
      end
      return l[CNT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/mdrb_ctrl.sv @@
`default_nettype none

module mdrb_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output mdrb_pkg::cmd_type  cmd
);

   mdrb_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdrb_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = mdrb_pkg::S_EXEC;
            end
         end
         mdrb_pkg::S_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = mdrb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mdrb_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         mdrb_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         mdrb_pkg::S_EXEC: begin
            cmd.execute = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdrb_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/mdrb_dpath.sv @@
`default_nettype none

module mdrb_dpath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  mdrb_pkg::cmd_type                   cmd,
   input  wire [mdrb_pkg::FUNC_BITS-1:0]       req_func,
   input  wire [mdrb_pkg::DATA_BITS-1:0]       req_data,
   input  wire                                 csr_we,
   input  wire [mdrb_pkg::QLEN_BITS-1:0]       csr_wdata,
   output mdrb_pkg::rsp_type                   rsp
);

   localparam int IB = mdrb_pkg::IDX_BITS;
   localparam int CB = mdrb_pkg::CNT_BITS;

   logic [mdrb_pkg::ITEM_BITS-1:0] mem [0:mdrb_pkg::DEPTH-1];

   mdrb_pkg::func_type             func_ff;
   logic [mdrb_pkg::ITEM_BITS-1:0] data_ff;
   logic [mdrb_pkg::ITEM_BITS-1:0] rd_ff;

   logic [IB-1:0] wi_ff, wi_in;
   logic [IB-1:0] ri_ff, ri_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [CB-1:0] len_ff, len_new;

   logic [IB-1:0] nri;
   logic [IB-1:0] mem_addr;
   logic          mem_we;
   logic          full;
   logic          empty;

   mdrb_pkg::rsp_type rsp_ff, rsp_in;

   assign nri     = (CB'(ri_ff) + CB'(1) >= len_ff) ? '0 : ri_ff + IB'(1);
   assign full    = cnt_ff >= len_ff;
   assign empty   = cnt_ff == '0;
   assign len_new = mdrb_pkg::eff_len(csr_wdata);

   always_comb begin
      wi_in                = wi_ff;
      ri_in                = ri_ff;
      cnt_in               = cnt_ff;
      mem_we               = 1'b0;
      mem_addr             = wi_ff;
      rsp_in.status        = mdrb_pkg::ST_PASS;
      rsp_in.read_data     = '0;
      case (func_ff)
         mdrb_pkg::FUNC_SEND_BACK: begin
            if (full) begin
               rsp_in.status = mdrb_pkg::ST_FULL;
            end else begin
               mem_we   = 1'b1;
               mem_addr = wi_ff;
               wi_in    = (CB'(wi_ff) + CB'(1) >= len_ff) ? '0 : wi_ff + IB'(1);
               cnt_in   = cnt_ff + CB'(1);
            end
         end
         mdrb_pkg::FUNC_SEND_FRONT: begin
            if (full) begin
               rsp_in.status = mdrb_pkg::ST_FULL;
            end else begin
               mem_we   = 1'b1;
               mem_addr = ri_ff;
               ri_in    = (ri_ff == '0) ? IB'(len_ff - CB'(1)) : ri_ff - IB'(1);
               cnt_in   = cnt_ff + CB'(1);
            end
         end
         mdrb_pkg::FUNC_RECEIVE: begin
            if (empty) begin
               rsp_in.status = mdrb_pkg::ST_EMPTY;
            end else begin
               rsp_in.read_data = mdrb_pkg::DATA_BITS'(rd_ff);
               ri_in            = nri;
               cnt_in           = cnt_ff - CB'(1);
            end
         end
         mdrb_pkg::FUNC_PEEK: begin
            if (empty) begin
               rsp_in.status = mdrb_pkg::ST_EMPTY;
            end else begin
               rsp_in.read_data = mdrb_pkg::DATA_BITS'(rd_ff);
            end
         end
         default: begin
            rsp_in.status = mdrb_pkg::ST_PASS;
         end
      endcase
      rsp_in.items_waiting = mdrb_pkg::WAIT_BITS'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[nri];
      end
      if (cmd.execute && mem_we) begin
         mem[mem_addr] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= mdrb_pkg::func_type'(req_func);
         data_ff <= mdrb_pkg::ITEM_BITS'(req_data);
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= mdrb_pkg::eff_len(mdrb_pkg::QLEN_RESET);
         wi_ff  <= '0;
         ri_ff  <= IB'(mdrb_pkg::eff_len(mdrb_pkg::QLEN_RESET) - CB'(1));
         cnt_ff <= '0;
      end else if (csr_we) begin
         len_ff <= len_new;
         wi_ff  <= '0;
         ri_ff  <= IB'(len_new - CB'(1));
         cnt_ff <= '0;
      end else if (cmd.execute) begin
         wi_ff  <= wi_in;
         ri_ff  <= ri_in;
         cnt_ff <= cnt_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

@@ sv/message_deque_ring_buffer.sv @@
// Channel  Direction  tdata (low bit up)                     tuser
// req_     in         [31:0] item_data                       [1:0] func
// rsp_     out        [31:0] read_data, [36:32] items_waiting [1:0] status
// csr_     in         csr_wdata [4:0] queue_length, written when csr_we
//
// Each item is first captured while the slot memory is read; then the
// indices and count are updated and the result register is loaded. The
// slot memory read is registered. Reset is synchronous and sets
// queue_length to 16 with an empty queue. While a result waits in the
// output register the next item is still taken; its update step holds
// until the waiting result is taken.
`default_nettype none

module message_deque_ring_buffer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,  // [31:0] item_data
   input  wire  [1:0]  req_tuser,  // [1:0] func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] read_data, [36:32] items_waiting
   output logic [1:0]  rsp_tuser,  // [1:0] status
   input  wire         csr_we,
   input  wire  [4:0]  csr_wdata
);

   mdrb_pkg::cmd_type cmd;
   mdrb_pkg::rsp_type rsp;

   mdrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mdrb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_func  (req_tuser),
      .req_data  (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.items_waiting, rsp.read_data};
   assign rsp_tuser = rsp.status;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == mdrb_pkg::ST_EMPTY)
      |-> (rsp_tdata[31:0] == 32'd0 && rsp_tdata[36:32] == 5'd0))
      else $error("empty status with data or items waiting");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == mdrb_pkg::ST_FULL)
      |-> (rsp_tdata[31:0] == 32'd0 && rsp_tdata[36:32] != 5'd0))
      else $error("full status with data or no items waiting");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[36:32]) <= mdrb_pkg::DEPTH))
      else $error("items waiting above ring depth");
`endif

endmodule

`default_nettype wire
